[hw/rtl/fst_pkg.sv]
// Shared types and constants for the four-channel tone synthesizer.
// No dependencies.
package fst_pkg;

    localparam int NUM_VOICES = 4;
    localparam int VOICE_AW   = 2;

    localparam logic [VOICE_AW-1:0] VOICE_NOISE = 2'd3;
    localparam logic [VOICE_AW-1:0] VOICE_TRI   = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_NOTE = 1'b1;

    localparam logic [1:0] REG_ATTACK = 2'd0;
    localparam logic [1:0] REG_DECAY  = 2'd1;
    localparam logic [1:0] REG_SEED   = 2'd2;

    localparam logic [7:0]  ATTACK_RST = 8'd44;
    localparam logic [15:0] DECAY_RST  = 16'd65527;
    localparam logic [31:0] SEED_RST   = 32'h2021_0110;

    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] LCG_ADD   = 32'd12345;
    localparam logic [31:0] NOISE_HI  = 32'h7fff_0000;
    localparam logic [29:0] NOISE_DEN = 30'h3fff_ffff;
    localparam logic [16:0] UNITY     = 17'h10000;

    typedef struct packed {
        logic busy;
        logic done;
    } fst_div_stat_t;

endpackage

[hw/rtl/fst_if.sv]
// Request and sample channel interfaces for the tone synthesizer.
// Uses no package.
interface fst_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [1:0]  voice;
    logic [23:0] phase_step;
    logic [23:0] length_samples;
    logic [23:0] delay_samples;
    logic [15:0] volume;
    logic        env_enable;

    modport source (output valid, opcode, voice, phase_step, length_samples,
                    delay_samples, volume, env_enable, input ready);
    modport sink (input valid, opcode, voice, phase_step, length_samples,
                  delay_samples, volume, env_enable, output ready);
endinterface

interface fst_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

[hw/rtl/four_channel_tone_synth.sv]
// Top level of the four-channel tone synthesizer.
// Depends on fst_pkg, fst_if, fst_voice_ram and fst_div.

// Four-voice sound generator: voices 0 and 1 are square, voice 2 triangle,
// voice 3 LCG noise. A note request (opcode 1) loads one voice and the
// block is ready again at once. A tick request (opcode 0) walks the four
// voices one at a time through the voice state memory and returns one
// mixed 16-bit sample. Per voice the walk passes READ and EVAL when the
// voice is finished, adds WB when it is still in its start delay, and
// adds MUL1, SCALE, MUL2, ROUND and WB when it sounds; noise adds the
// NOISE state for its two LCG steps and a voice inside its attack ramp
// waits in DIV for the bit-serial ramp divider. The finished sample sits
// in an output register, so the next request is taken while it waits; a
// following tick holds in its output state until that sample is taken.
// Configuration (attack length, decay factor, noise seed) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while
// no tick is in progress, which the block itself does not enforce;
// writing the seed also reloads the noise generator.
module four_channel_tone_synth #(
    parameter int PHASE_BITS = 24,
    parameter int COUNT_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    fst_req_if.sink    req,
    fst_smp_if.source  smp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CW   = COUNT_BITS + 1;
    localparam int EW   = CW + COUNT_BITS + PHASE_BITS + 16 + 1 + PHASE_BITS + 17;
    localparam int MAGW = (PHASE_BITS + 1 > 30) ? PHASE_BITS + 1 : 30;
    localparam int PW   = 32 + MAGW;
    localparam int TW   = PHASE_BITS + 3;
    localparam logic [EW-1:0] ENT_INIT = EW'(fst_pkg::UNITY);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_READ  = 11'b000_0000_0010,
        S_EVAL  = 11'b000_0000_0100,
        S_DIV   = 11'b000_0000_1000,
        S_MUL1  = 11'b000_0001_0000,
        S_SCALE = 11'b000_0010_0000,
        S_NOISE = 11'b000_0100_0000,
        S_MUL2  = 11'b000_1000_0000,
        S_ROUND = 11'b001_0000_0000,
        S_WB    = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [7:0]  attack_reg;
    logic [15:0] decay_reg;
    logic [31:0] lcg_reg;

    // sequencing
    logic [1:0]  vidx_reg, vidx_next;
    logic        active_reg;
    logic        noise_ph_reg;

    // datapath
    logic [15:0]     acc_reg;
    logic [16:0]     env_reg;
    logic [32:0]     prod1_reg;
    logic [31:0]     m_reg;
    logic [MAGW-1:0] mag_reg;
    logic            neg_reg;
    logic [PW-1:0]   prod2_reg;
    logic [31:0]     noise_a_reg;

    logic        out_valid_reg;
    logic [15:0] out_sample_reg;

    // voice memory
    logic                  ram_we;
    logic [1:0]            ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [EW-1:0]         ram_rdata;

    logic [CW-1:0]         e_cnt;
    logic [COUNT_BITS-1:0] e_len;
    logic [PHASE_BITS-1:0] e_step;
    logic [15:0]           e_vol;
    logic                  e_env;
    logic [PHASE_BITS-1:0] e_phase;
    logic [16:0]           e_dec;

    assign {e_cnt, e_len, e_step, e_vol, e_env, e_phase, e_dec} = ram_rdata;

    logic req_take;
    logic out_free;
    logic finished;
    logic in_attack;

    assign req_take = req.valid && req.ready;
    assign out_free = !out_valid_reg || smp.ready;
    assign finished = $signed(e_cnt) >= $signed({1'b0, e_len});
    assign in_attack = e_env && (e_cnt < CW'(attack_reg));

    // attack ramp divider
    logic [15:0]            div_quo;
    fst_pkg::fst_div_stat_t div_stat;
    logic                   div_start;

    assign div_start = (state_reg == S_EVAL) && !finished && !e_cnt[CW-1] && in_attack;

    fst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (e_cnt[7:0]),
        .den   (attack_reg),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // noise generator step
    logic [31:0] lcg_step;
    logic [29:0] noise_i;
    logic [31:0] noise_n;
    assign lcg_step = 32'(lcg_reg * fst_pkg::LCG_MUL) + fst_pkg::LCG_ADD;
    assign noise_i  = {noise_a_reg[30:16], lcg_step[30:16]};
    assign noise_n  = {1'b0, noise_i, 1'b0} - {2'b00, fst_pkg::NOISE_DEN};

    // triangle numerator: 4p - one on the rising half, 3*one - 4p after
    logic [TW-1:0] tri_p4;
    logic [TW-1:0] tri_one;
    logic [TW-1:0] tri_num;
    assign tri_p4  = {1'b0, e_phase, 2'b00};
    assign tri_one = TW'(1) << PHASE_BITS;
    assign tri_num = e_phase[PHASE_BITS-1] ? (TW'(3) * tri_one) - tri_p4 : tri_p4 - tri_one;

    // rounding of m * mag back to the sample scale
    logic [PW:0]   rnd_sq;
    logic [PW:0]   rnd_tri;
    logic [PW:0]   rnd_ns;
    logic [PW:0]   ns_hi;
    logic [PW:0]   ns_r;
    logic [15:0]   q_mag;
    logic [15:0]   contrib;

    assign rnd_sq  = ({1'b0, prod2_reg} + (PW+1)'(1 << 15)) >> 16;
    assign rnd_tri = ({1'b0, prod2_reg} + ((PW+1)'(1) << (PHASE_BITS + 15)))
                     >> (PHASE_BITS + 16);
    // divide by 2^30-1: fold the high part back in, then one correction
    assign rnd_ns  = ({1'b0, prod2_reg} + ((PW+1)'(fst_pkg::NOISE_DEN) << 15)) >> 16;
    assign ns_hi   = rnd_ns >> 30;
    assign ns_r    = (PW+1)'(rnd_ns[29:0]) + ns_hi;

    always_comb
    begin
        if (vidx_reg == fst_pkg::VOICE_NOISE)
        begin
            q_mag = 16'(ns_hi + ((ns_r >= (PW+1)'(fst_pkg::NOISE_DEN)) ? 1 : 0));
        end
        else if (vidx_reg == fst_pkg::VOICE_TRI)
        begin
            q_mag = rnd_tri[15:0];
        end
        else
        begin
            q_mag = rnd_sq[15:0];
        end
    end

    assign contrib = neg_reg ? 16'(-q_mag) : q_mag;

    // write-back entry
    logic [32:0]           dec_prod;
    logic [16:0]           dec_new;
    logic [PHASE_BITS-1:0] phase_new;
    assign dec_prod  = e_dec * decay_reg;
    assign dec_new   = dec_prod[32:16];
    assign phase_new = e_phase + e_step;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = vidx_reg;
        ram_wdata = {CW'(e_cnt + CW'(1)), e_len, e_step, e_vol, e_env,
                     active_reg ? phase_new : e_phase,
                     active_reg ? dec_new : e_dec};
        if (state_reg == S_IDLE && req_take && req.opcode == fst_pkg::OP_NOTE)
        begin
            ram_we    = 1'b1;
            ram_waddr = req.voice;
            ram_wdata = {CW'(-CW'(COUNT_BITS'(req.delay_samples))),
                         COUNT_BITS'(req.length_samples),
                         PHASE_BITS'(req.phase_step),
                         req.volume, req.env_enable,
                         PHASE_BITS'(0), fst_pkg::UNITY};
        end
        else if (state_reg == S_WB)
        begin
            ram_we = 1'b1;
        end
    end

    fst_voice_ram #(.W(EW), .INIT(ENT_INIT)) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (vidx_reg),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        vidx_next  = vidx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take && req.opcode == fst_pkg::OP_TICK)
                begin
                    vidx_next  = '0;
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_EVAL;
            S_EVAL:
            begin
                if (finished)
                begin
                    if (vidx_reg == 2'd3)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 2'd1;
                        state_next = S_READ;
                    end
                end
                else if (e_cnt[CW-1])
                begin
                    state_next = S_WB;
                end
                else if (in_attack)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end
            S_DIV:   state_next = div_stat.done ? S_MUL1 : S_DIV;
            S_MUL1:  state_next = S_SCALE;
            S_SCALE: state_next = (vidx_reg == fst_pkg::VOICE_NOISE) ? S_NOISE : S_MUL2;
            S_NOISE: state_next = noise_ph_reg ? S_MUL2 : S_NOISE;
            S_MUL2:  state_next = S_ROUND;
            S_ROUND: state_next = S_WB;
            S_WB:
            begin
                if (vidx_reg == 2'd3)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    vidx_next  = vidx_reg + 2'd1;
                    state_next = S_READ;
                end
            end
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vidx_reg      <= '0;
            attack_reg    <= fst_pkg::ATTACK_RST;
            decay_reg     <= fst_pkg::DECAY_RST;
            lcg_reg       <= fst_pkg::SEED_RST;
            noise_ph_reg  <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vidx_reg  <= vidx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fst_pkg::REG_ATTACK: attack_reg <= cfg_data[7:0];
                    fst_pkg::REG_DECAY:  decay_reg  <= cfg_data[15:0];
                    fst_pkg::REG_SEED:   lcg_reg    <= cfg_data;
                    default:             ;
                endcase
            end
            else if (state_reg == S_NOISE)
            begin
                lcg_reg <= lcg_step;
            end
            if (state_reg == S_NOISE)
            begin
                noise_ph_reg <= !noise_ph_reg;
            end
            if (state_reg == S_EVAL)
            begin
                active_reg <= !e_cnt[CW-1];
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (smp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:  acc_reg <= '0;
            S_EVAL:  env_reg <= e_env ? e_dec : fst_pkg::UNITY;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    env_reg <= {1'b0, div_quo};
                end
            end
            S_MUL1:  prod1_reg <= e_vol * env_reg;
            S_SCALE:
            begin
                // m = vol * env * 32767 / 2^16
                m_reg <= 32'(({prod1_reg, 15'b0} - 48'(prod1_reg)) >> 16);
                if (vidx_reg == fst_pkg::VOICE_TRI)
                begin
                    neg_reg <= tri_num[TW-1];
                    mag_reg <= MAGW'(tri_num[TW-1] ? TW'(-tri_num) : tri_num);
                end
                else
                begin
                    neg_reg <= e_phase[PHASE_BITS-1];
                    mag_reg <= MAGW'(1);
                end
            end
            S_NOISE:
            begin
                if (!noise_ph_reg)
                begin
                    noise_a_reg <= lcg_step & fst_pkg::NOISE_HI;
                end
                else
                begin
                    neg_reg <= noise_n[31];
                    mag_reg <= MAGW'(noise_n[31] ? 32'(-noise_n) : noise_n);
                end
            end
            S_MUL2:  prod2_reg <= m_reg * mag_reg;
            S_ROUND: acc_reg <= acc_reg + contrib;
            S_OUT:
            begin
                if (out_free)
                begin
                    out_sample_reg <= {acc_reg[15], acc_reg[15:1]};
                end
            end
            default: ;
        endcase
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign smp.valid  = out_valid_reg;
    assign smp.sample = out_sample_reg;
endmodule

[hw/rtl/fst_voice_ram.sv]
// Per-voice state memory: 4 entries, one write port, registered read.
// Depends on fst_pkg.
module fst_voice_ram #(
    parameter int W = 8,
    parameter logic [W-1:0] INIT = '0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [fst_pkg::VOICE_AW-1:0]  waddr,
    input  logic [W-1:0]                  wdata,
    input  logic [fst_pkg::VOICE_AW-1:0]  raddr,
    output logic [W-1:0]                  rdata
);
    logic [W-1:0]                    mem [fst_pkg::NUM_VOICES];
    logic [fst_pkg::NUM_VOICES-1:0]  valid_reg;
    logic [W-1:0]                    rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : INIT;
    end

    // unwritten entries read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/fst_div.sv]
// Restoring divider for the attack ramp: q = floor(num * 65536 / den), num < den.
// Depends on fst_pkg.
module fst_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [7:0]            num,
    input  logic [7:0]            den,
    output logic [15:0]           quo,
    output fst_pkg::fst_div_stat_t stat
);
    logic [7:0]  rem_reg;
    logic [15:0] quo_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [8:0]  rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg, 1'b0};
    assign fits   = rem_sh >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'hf;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 8'(rem_sh - {1'b0, den}) : rem_sh[7:0];
            quo_reg <= {quo_reg[14:0], fits};
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

[hw/rtl/fst_checker.sv]
// Port-level checks for the tone synthesizer, bound to the top level.
// Depends on four_channel_tone_synth and fst_pkg.
module fst_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_opcode,
    input logic smp_valid,
    input logic smp_ready
);
    // a tick request starts a walk over the voices
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_opcode == fst_pkg::OP_TICK |=> !req_ready)
        else $error("ready after tick request");

    // a note request leaves the block ready in the next cycle
    a_note_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_opcode == fst_pkg::OP_NOTE |=> req_ready)
        else $error("not ready after note request");

    // a new sample only comes from a tick in progress
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(smp_valid) |-> $past(!req_ready))
        else $error("sample without tick");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_ready |=> smp_valid)
        else $error("sample dropped");
endmodule

bind four_channel_tone_synth fst_checker u_fst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_opcode (req.opcode),
    .smp_valid  (smp.valid),
    .smp_ready  (smp.ready)
);
